// ===== rtl/core/qrrs_pkg.sv =====
// shared types and constants of the quadratic real-root solver
package qrrs_pkg;

    // status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_DEGEN = 2'd1;
    localparam logic [1:0] STATUS_SAT   = 2'd2;

    // root counts
    localparam logic [1:0] COUNT_NONE = 2'd0;
    localparam logic [1:0] COUNT_ONE  = 2'd1;
    localparam logic [1:0] COUNT_TWO  = 2'd2;

    // square root: 35 result bits, two radicand bits per step
    localparam int SQRT_STEPS = 35;
    localparam int RAD_W      = 2 * SQRT_STEPS;
    localparam int DISC_W     = 66;
    localparam int SREM_W     = 37;
    localparam int ROOT_W     = SQRT_STEPS;

    // divider: numerator magnitude below 2^34, divisor 2|a| below 2^33
    localparam int NUM_W  = 34;
    localparam int DEN_W  = 33;
    localparam int DREM_W = 34;

    typedef struct packed {
        logic signed [31:0] coef_a;
        logic signed [31:0] coef_b;
        logic signed [31:0] coef_c;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         root_count;
        logic signed [31:0] root_first;
        logic signed [31:0] root_second;
        logic [1:0]         status;
    } out_item_t;

    // flags and operands riding alongside the square root chain
    typedef struct packed {
        logic               degen;
        logic               dneg;
        logic               dzero;
        logic               a_neg;
        logic [31:0]        a_mag;
        logic signed [31:0] b;
    } sq_side_t;

    // flags riding alongside the divider chain
    typedef struct packed {
        logic degen;
        logic dneg;
        logic dzero;
        logic neg_first;
        logic neg_second;
    } div_side_t;

endpackage

// ===== rtl/core/quadratic_real_root_solver.sv =====
// top level of the pipelined quadratic real-root solver
//
//  channel | valid      | stall      | payload | direction
//  --------+------------+------------+---------+----------
//  coef    | coef_valid | coef_stall | coef    | in
//  root    | root_valid | root_stall | root    | out
//
// one item enters per cycle while the chain advances; the registers in order are the
// product stage, discriminant stage, 35 square root cells, numerator
// stage, 34 + FRAC_BITS divider cells and the output register.
// the whole chain moves together; it halts only while a result sits in
// the output register and root_stall is high, and then coef_stall rises.
// reset clears the valid bit of every stage, the output register's included.
module quadratic_real_root_solver #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 coef_valid,
    output logic                 coef_stall,
    input  qrrs_pkg::in_item_t   coef,
    output logic                 root_valid,
    input  logic                 root_stall,
    output qrrs_pkg::out_item_t  root
);

    // dividend width: numerator magnitude with the fraction shift applied
    localparam int DW    = qrrs_pkg::NUM_W + FRAC_BITS;
    localparam int STEPS = qrrs_pkg::SQRT_STEPS;

    // chain advance: everything moves unless a held result blocks the exit
    logic adv;
    assign adv        = !root_valid || !root_stall;
    assign coef_stall = !adv;

    // ---------------------------------------------------------------
    // stage 1: coefficient magnitudes and the two products b*b and a*c
    // ---------------------------------------------------------------
    logic [31:0]        a_mag;
    logic [31:0]        b_mag;
    logic [31:0]        c_mag;
    logic               v1_reg;
    logic [63:0]        b2_reg;
    logic [63:0]        ac_reg;
    logic               f_neg_reg;
    logic               degen1_reg;
    logic               a_neg1_reg;
    logic [31:0]        a_mag1_reg;
    logic signed [31:0] b1_reg;

    always_comb
    begin
        a_mag = coef.coef_a[31] ? (32'd0 - coef.coef_a) : coef.coef_a;
        b_mag = coef.coef_b[31] ? (32'd0 - coef.coef_b) : coef.coef_b;
        c_mag = coef.coef_c[31] ? (32'd0 - coef.coef_c) : coef.coef_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= coef_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b2_reg     <= b_mag * b_mag;
            ac_reg     <= a_mag * c_mag;
            // 4ac has opposite sign to b*b only when a and c differ in sign
            f_neg_reg  <= (coef.coef_c != 32'sd0) && (coef.coef_a[31] != coef.coef_c[31]);
            degen1_reg <= (coef.coef_a == 32'sd0);
            a_neg1_reg <= coef.coef_a[31];
            a_mag1_reg <= a_mag;
            b1_reg     <= coef.coef_b;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: discriminant b*b - 4ac as sign and magnitude
    // ---------------------------------------------------------------
    logic [qrrs_pkg::DISC_W-1:0] f_w;
    logic [qrrs_pkg::DISC_W-1:0] b2_w;
    logic [qrrs_pkg::DISC_W-1:0] d_mag;
    logic                        d_neg;
    logic                        v2_reg;
    logic [qrrs_pkg::RAD_W-1:0]  rad2_reg;
    qrrs_pkg::sq_side_t          side2_reg;

    always_comb
    begin
        f_w  = {ac_reg, 2'b00};
        b2_w = {2'b00, b2_reg};
        if (f_neg_reg)
        begin
            d_mag = b2_w + f_w;
            d_neg = 1'b0;
        end
        else if (f_w <= b2_w)
        begin
            d_mag = b2_w - f_w;
            d_neg = 1'b0;
        end
        else
        begin
            d_mag = f_w - b2_w;
            d_neg = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // a negative discriminant is never rooted, so feed zero
            rad2_reg        <= d_neg ? '0 : qrrs_pkg::RAD_W'(d_mag);
            side2_reg.degen <= degen1_reg;
            side2_reg.dneg  <= d_neg;
            side2_reg.dzero <= (d_mag == '0);
            side2_reg.a_neg <= a_neg1_reg;
            side2_reg.a_mag <= a_mag1_reg;
            side2_reg.b     <= b1_reg;
        end
    end

    // ---------------------------------------------------------------
    // square root chain: one root bit per cell, floor result
    // ---------------------------------------------------------------
    logic [qrrs_pkg::RAD_W-1:0]  rad_w  [STEPS+1];
    logic [qrrs_pkg::SREM_W-1:0] srem_w [STEPS+1];
    logic [qrrs_pkg::ROOT_W-1:0] sroot_w[STEPS+1];
    logic                        vs_reg [STEPS];
    qrrs_pkg::sq_side_t          ss_reg [STEPS];

    assign rad_w[0]   = rad2_reg;
    assign srem_w[0]  = '0;
    assign sroot_w[0] = '0;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_sqrt
        qrrs_sqrt_cell u_cell (
            .clk      (clk),
            .en       (adv),
            .rad      (rad_w[i]),
            .rem      (srem_w[i]),
            .root     (sroot_w[i]),
            .rad_reg  (rad_w[i+1]),
            .rem_reg  (srem_w[i+1]),
            .root_reg (sroot_w[i+1])
        );
    end

    // flags travel in step with the cells
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STEPS; i++)
            begin
                vs_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vs_reg[0] <= v2_reg;
            for (int i = 1; i < STEPS; i++)
            begin
                vs_reg[i] <= vs_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ss_reg[0] <= side2_reg;
            for (int i = 1; i < STEPS; i++)
            begin
                ss_reg[i] <= ss_reg[i-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // numerator stage: -b -/+ sqrt(D), magnitudes and quotient signs
    // ---------------------------------------------------------------
    qrrs_pkg::sq_side_t          sq_out;
    logic signed [35:0]          nb;
    logic signed [35:0]          sroot_s;
    logic signed [35:0]          n_first;
    logic signed [35:0]          n_second;
    logic [35:0]                 m_first;
    logic [35:0]                 m_second;
    logic                        vn_reg;
    logic [DW-1:0]               num1_reg;
    logic [DW-1:0]               num2_reg;
    logic [qrrs_pkg::DEN_W-1:0]  den_reg;
    qrrs_pkg::div_side_t         dside_reg;

    always_comb
    begin
        sq_out   = ss_reg[STEPS-1];
        nb       = 36'sd0 - 36'(sq_out.b);
        sroot_s  = $signed({1'b0, sroot_w[STEPS]});
        n_first  = nb - sroot_s;
        n_second = nb + sroot_s;
        m_first  = n_first[35]  ? (36'd0 - n_first)  : n_first;
        m_second = n_second[35] ? (36'd0 - n_second) : n_second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vn_reg <= 1'b0;
        end
        else if (adv)
        begin
            vn_reg <= vs_reg[STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num1_reg             <= DW'(m_first[qrrs_pkg::NUM_W-1:0]) << FRAC_BITS;
            num2_reg             <= DW'(m_second[qrrs_pkg::NUM_W-1:0]) << FRAC_BITS;
            den_reg              <= {sq_out.a_mag, 1'b0};
            dside_reg.degen      <= sq_out.degen;
            dside_reg.dneg       <= sq_out.dneg;
            dside_reg.dzero      <= sq_out.dzero;
            dside_reg.neg_first  <= n_first[35] != sq_out.a_neg;
            dside_reg.neg_second <= n_second[35] != sq_out.a_neg;
        end
    end

    // ---------------------------------------------------------------
    // divider chains: two lanes side by side, one quotient bit per cell
    // ---------------------------------------------------------------
    logic [DW-1:0]               num_a [DW+1];
    logic [qrrs_pkg::DREM_W-1:0] rem_a [DW+1];
    logic [DW-1:0]               quo_a [DW+1];
    logic [qrrs_pkg::DEN_W-1:0]  den_a [DW+1];
    logic [DW-1:0]               num_b [DW+1];
    logic [qrrs_pkg::DREM_W-1:0] rem_b [DW+1];
    logic [DW-1:0]               quo_b [DW+1];
    logic [qrrs_pkg::DEN_W-1:0]  den_b [DW+1];
    logic                        vd_reg[DW];
    qrrs_pkg::div_side_t         ds_reg[DW];

    assign num_a[0] = num1_reg;
    assign rem_a[0] = '0;
    assign quo_a[0] = '0;
    assign den_a[0] = den_reg;
    assign num_b[0] = num2_reg;
    assign rem_b[0] = '0;
    assign quo_b[0] = '0;
    assign den_b[0] = den_reg;

    for (genvar i = 0; i < DW; i++)
    begin : g_div
        qrrs_div_cell #(.DW(DW)) u_first (
            .clk     (clk),
            .en      (adv),
            .num     (num_a[i]),
            .rem     (rem_a[i]),
            .quo     (quo_a[i]),
            .den     (den_a[i]),
            .num_reg (num_a[i+1]),
            .rem_reg (rem_a[i+1]),
            .quo_reg (quo_a[i+1]),
            .den_reg (den_a[i+1])
        );
        qrrs_div_cell #(.DW(DW)) u_second (
            .clk     (clk),
            .en      (adv),
            .num     (num_b[i]),
            .rem     (rem_b[i]),
            .quo     (quo_b[i]),
            .den     (den_b[i]),
            .num_reg (num_b[i+1]),
            .rem_reg (rem_b[i+1]),
            .quo_reg (quo_b[i+1]),
            .den_reg (den_b[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DW; i++)
            begin
                vd_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vd_reg[0] <= vn_reg;
            for (int i = 1; i < DW; i++)
            begin
                vd_reg[i] <= vd_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ds_reg[0] <= dside_reg;
            for (int i = 1; i < DW; i++)
            begin
                ds_reg[i] <= ds_reg[i-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // output stage: sign, saturation, count and status
    // ---------------------------------------------------------------
    localparam logic [DW-1:0] POS_MAX = DW'(33'h0_7FFF_FFFF);
    localparam logic [DW-1:0] NEG_MAX = DW'(33'h0_8000_0000);

    qrrs_pkg::div_side_t fs;
    logic [DW-1:0]       q1;
    logic [DW-1:0]       q2;
    logic                sat1;
    logic                sat2;
    logic signed [31:0]  r1;
    logic signed [31:0]  r2;
    qrrs_pkg::out_item_t root_next;
    logic                root_valid_reg;
    qrrs_pkg::out_item_t root_reg;

    always_comb
    begin
        fs = ds_reg[DW-1];
        q1 = quo_a[DW];
        q2 = quo_b[DW];
        if (fs.neg_first)
        begin
            sat1 = (q1 > NEG_MAX);
            r1   = sat1 ? 32'sh8000_0000 : $signed(32'd0 - q1[31:0]);
        end
        else
        begin
            sat1 = (q1 > POS_MAX);
            r1   = sat1 ? 32'sh7FFF_FFFF : $signed(q1[31:0]);
        end
        if (fs.neg_second)
        begin
            sat2 = (q2 > NEG_MAX);
            r2   = sat2 ? 32'sh8000_0000 : $signed(32'd0 - q2[31:0]);
        end
        else
        begin
            sat2 = (q2 > POS_MAX);
            r2   = sat2 ? 32'sh7FFF_FFFF : $signed(q2[31:0]);
        end

        if (fs.degen)
        begin
            root_next.root_count  = qrrs_pkg::COUNT_NONE;
            root_next.root_first  = '0;
            root_next.root_second = '0;
            root_next.status      = qrrs_pkg::STATUS_DEGEN;
        end
        else if (fs.dneg)
        begin
            root_next.root_count  = qrrs_pkg::COUNT_NONE;
            root_next.root_first  = '0;
            root_next.root_second = '0;
            root_next.status      = qrrs_pkg::STATUS_OK;
        end
        else
        begin
            // a zero discriminant runs both lanes with a zero root, so they agree
            root_next.root_count  = fs.dzero ? qrrs_pkg::COUNT_ONE : qrrs_pkg::COUNT_TWO;
            root_next.root_first  = r1;
            root_next.root_second = r2;
            root_next.status      = (sat1 || sat2) ? qrrs_pkg::STATUS_SAT
                                                   : qrrs_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            root_valid_reg <= vd_reg[DW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            root_reg <= root_next;
        end
    end

    assign root_valid = root_valid_reg;
    assign root       = root_reg;

endmodule

// ===== rtl/core/qrrs_sqrt_cell.sv =====
// one restoring square root step: two radicand bits in, one root bit out
module qrrs_sqrt_cell (
    input  logic                              clk,
    input  logic                              en,
    input  logic [qrrs_pkg::RAD_W-1:0]        rad,
    input  logic [qrrs_pkg::SREM_W-1:0]       rem,
    input  logic [qrrs_pkg::ROOT_W-1:0]       root,
    output logic [qrrs_pkg::RAD_W-1:0]        rad_reg,
    output logic [qrrs_pkg::SREM_W-1:0]       rem_reg,
    output logic [qrrs_pkg::ROOT_W-1:0]       root_reg
);

    logic [qrrs_pkg::SREM_W-1:0] rem_sh;
    logic [qrrs_pkg::SREM_W-1:0] trial;
    logic                        ge;
    logic [qrrs_pkg::RAD_W-1:0]  rad_next;
    logic [qrrs_pkg::SREM_W-1:0] rem_next;
    logic [qrrs_pkg::ROOT_W-1:0] root_next;

    always_comb
    begin
        rem_sh    = {rem[qrrs_pkg::SREM_W-3:0], rad[qrrs_pkg::RAD_W-1 -: 2]};
        trial     = {root, 2'b01};
        ge        = (rem_sh >= trial);
        rem_next  = ge ? (rem_sh - trial) : rem_sh;
        root_next = {root[qrrs_pkg::ROOT_W-2:0], ge};
        rad_next  = {rad[qrrs_pkg::RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

endmodule

// ===== rtl/core/qrrs_div_cell.sv =====
// one restoring division step: one dividend bit in, one quotient bit out
module qrrs_div_cell #(
    parameter int DW = 50
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [DW-1:0]                 num,
    input  logic [qrrs_pkg::DREM_W-1:0]   rem,
    input  logic [DW-1:0]                 quo,
    input  logic [qrrs_pkg::DEN_W-1:0]    den,
    output logic [DW-1:0]                 num_reg,
    output logic [qrrs_pkg::DREM_W-1:0]   rem_reg,
    output logic [DW-1:0]                 quo_reg,
    output logic [qrrs_pkg::DEN_W-1:0]    den_reg
);

    logic [qrrs_pkg::DREM_W-1:0] rem_sh;
    logic [qrrs_pkg::DREM_W-1:0] den_ext;
    logic                        ge;
    logic [qrrs_pkg::DREM_W-1:0] rem_next;
    logic [DW-1:0]               quo_next;
    logic [DW-1:0]               num_next;

    always_comb
    begin
        rem_sh   = {rem[qrrs_pkg::DREM_W-2:0], num[DW-1]};
        den_ext  = {1'b0, den};
        ge       = (rem_sh >= den_ext);
        rem_next = ge ? (rem_sh - den_ext) : rem_sh;
        quo_next = {quo[DW-2:0], ge};
        num_next = {num[DW-2:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            den_reg <= den;
        end
    end

endmodule

// ===== rtl/core/qrrs_checker.sv =====
// port-level checks for the quadratic real-root solver, bound to the top level
module qrrs_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                coef_valid,
    input logic                coef_stall,
    input qrrs_pkg::in_item_t  coef,
    input logic                root_valid,
    input logic                root_stall,
    input qrrs_pkg::out_item_t root
);

    a_hold_valid : assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && root_stall |=> root_valid)
        else $error("result dropped while stalled");

    a_hold_item : assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && root_stall |=> $stable(root))
        else $error("result changed while stalled");

    a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
        root_valid |-> (root.root_count != 2'd3) && (root.status != 2'd3))
        else $error("count or status out of range");

    a_degen_clean : assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && root.status == qrrs_pkg::STATUS_DEGEN |->
            root.root_count == qrrs_pkg::COUNT_NONE && root.root_first == 32'sd0
            && root.root_second == 32'sd0)
        else $error("degenerate item carries roots");

    a_single_root : assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && root.root_count == qrrs_pkg::COUNT_ONE |->
            root.root_first == root.root_second)
        else $error("single root fields differ");

endmodule

bind quadratic_real_root_solver qrrs_checker u_qrrs_checker (.*);

// ===== tb/sv/qrrs_checker.sv =====
// checker for the quadratic real-root solver: predicts roots and compares results
`timescale 1ns / 1ps

module tb_qrrs_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          coef_valid,
    input  logic                          coef_stall,
    input  qrrs_pkg::in_item_t            coef,
    input  logic                          root_valid,
    input  logic                          root_stall,
    input  qrrs_pkg::out_item_t           root,
    output int                            fail_count,
    output int                            pending_roots,
    output int                            results_seen
);

    qrrs_pkg::out_item_t expected_roots[$];

    // quotient (num << 16) / (2a), truncated toward zero, saturated
    function automatic logic signed [31:0] div_root(input logic signed [63:0] num,
                                                    input logic signed [63:0] a,
                                                    inout logic sat);
        logic [63:0] mag;
        logic [63:0] den;
        logic [63:0] q;
        logic        neg;
        mag = (num < 0 ? -num : num) << 16;
        den = (a < 0 ? -a : a) << 1;
        q   = mag / den;
        neg = (num < 0) != (a < 0);
        if (neg)
        begin
            if (q > 64'h8000_0000)
            begin
                sat = 1'b1;
                return 32'sh8000_0000;
            end
            return -q[31:0];
        end
        if (q > 64'h7FFF_FFFF)
        begin
            sat = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        return q[31:0];
    endfunction

    function automatic qrrs_pkg::out_item_t solve_roots(input qrrs_pkg::in_item_t it);
        qrrs_pkg::out_item_t   r;
        logic signed [127:0]   disc;
        logic [127:0]          s;
        logic [127:0]          t;
        logic signed [63:0]    a;
        logic signed [63:0]    nb;
        logic                  sat;
        r = '0;
        sat = 1'b0;
        a = it.coef_a;
        nb = -64'(signed'(it.coef_b));
        r.status = qrrs_pkg::STATUS_OK;
        r.root_count = qrrs_pkg::COUNT_NONE;
        if (it.coef_a == 0)
            r.status = qrrs_pkg::STATUS_DEGEN;
        else
        begin
            disc = 128'(signed'(it.coef_b)) * 128'(signed'(it.coef_b))
                 - 128'sd4 * 128'(signed'(it.coef_a)) * 128'(signed'(it.coef_c));
            if (disc == 0)
            begin
                r.root_count = qrrs_pkg::COUNT_ONE;
                r.root_first = div_root(nb, a, sat);
                r.root_second = r.root_first;
            end
            else if (disc > 0)
            begin
                s = 0;
                for (int k = 34; k >= 0; k--)
                begin
                    t = s | (128'd1 << k);
                    if (t * t <= disc)
                        s = t;
                end
                r.root_count = qrrs_pkg::COUNT_TWO;
                r.root_first = div_root(nb - 64'(s), a, sat);
                r.root_second = div_root(nb + 64'(s), a, sat);
            end
            if (sat)
                r.status = qrrs_pkg::STATUS_SAT;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        qrrs_pkg::out_item_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            results_seen <= 0;
            pending_roots <= 0;
            expected_roots.delete();
        end
        else
        begin
            if (coef_valid && !coef_stall)
                expected_roots.push_back(solve_roots(coef));
            if (root_valid && !root_stall)
            begin
                results_seen <= results_seen + 1;
                if (expected_roots.size() == 0)
                begin
                    $error("unexpected root item");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_roots.pop_front();
                    if (want !== root)
                    begin
                        if (want.root_count !== root.root_count)
                            $error("root_count exp %0d got %0d", want.root_count,
                                   root.root_count);
                        if (want.root_first !== root.root_first)
                            $error("root_first exp %0d got %0d", want.root_first,
                                   root.root_first);
                        if (want.root_second !== root.root_second)
                            $error("root_second exp %0d got %0d", want.root_second,
                                   root.root_second);
                        if (want.status !== root.status)
                            $error("status exp %0d got %0d", want.status, root.status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_roots <= expected_roots.size();
        end
    end
endmodule

// ===== tb/sv/tb_quadratic_real_root_solver.sv =====
// testbench top for the quadratic real-root solver: stimulus and verdict
`timescale 1ns / 1ps

module tb_quadratic_real_root_solver;

    // pipeline depth of the block
    localparam int LATENCY    = 39 + 34 + 16;
    localparam int STALL_LIMIT = 20000;

    logic                clk;
    logic                rst_n;
    logic                coef_valid;
    logic                coef_stall;
    qrrs_pkg::in_item_t  coef;
    logic                root_valid;
    logic                root_stall;
    qrrs_pkg::out_item_t root;
    int                  fail_count;
    int                  pending_roots;
    int                  results_seen;
    int                  items_sent;
    int                  idle_pct_send;
    int                  idle_pct_recv;
    bit                  hold_off;
    int                  quiet_cycles;

    quadratic_real_root_solver u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef_valid (coef_valid),
        .coef_stall (coef_stall),
        .coef       (coef),
        .root_valid (root_valid),
        .root_stall (root_stall),
        .root       (root)
    );

    tb_qrrs_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .coef_valid    (coef_valid),
        .coef_stall    (coef_stall),
        .coef          (coef),
        .root_valid    (root_valid),
        .root_stall    (root_stall),
        .root          (root),
        .fail_count    (fail_count),
        .pending_roots (pending_roots),
        .results_seen  (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog: counts cycles in which neither channel moves an item
    always @(posedge clk)
    begin
        if ((coef_valid && !coef_stall) || (root_valid && !root_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_off)
            root_stall <= 1'b1;
        else
            root_stall <= ($urandom_range(99) < idle_pct_recv);
    end

    // random coefficient with a bias towards small and edge magnitudes
    function automatic logic signed [31:0] pick_coef();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $signed($urandom_range(1 << 20)) - (1 << 19);
            2: return $signed($urandom_range(1 << 12)) - (1 << 11);
            3: return ($urandom_range(1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            4: return 0;
            default: return $signed($urandom_range(16) - 8) <<< 16;
        endcase
    endfunction

    // offer one item and hold it until accepted; valid stays high for the next one
    task automatic send_item(input logic signed [31:0] a, input logic signed [31:0] b,
                             input logic signed [31:0] c);
        while ($urandom_range(99) < idle_pct_send)
        begin
            coef_valid <= 1'b0;
            @(posedge clk);
        end
        coef_valid <= 1'b1;
        coef <= '{coef_a: a, coef_b: b, coef_c: c};
        @(posedge clk);
        while (coef_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // a well-posed quadratic from integer roots r1, r2: a(x-r1)(x-r2)
    task automatic send_real_roots();
        int ka;
        int r1;
        int r2;
        ka = $urandom_range(8) + 1;
        if ($urandom_range(1))
            ka = -ka;
        r1 = $urandom_range(60) - 30;
        r2 = ($urandom_range(3) == 0) ? r1 : $urandom_range(60) - 30;
        send_item(ka <<< 16, (-ka * (r1 + r2)) <<< 16, (ka * r1 * r2) <<< 16);
    endtask

    task automatic wait_drained();
        coef_valid <= 1'b0;
        @(posedge clk);
        while (pending_roots != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        coef_valid = 1'b0;
        coef = '0;
        root_stall = 1'b0;
        hold_off = 1'b0;
        quiet_cycles = 0;
        items_sent = 0;
        idle_pct_send = 0;
        idle_pct_recv = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: degenerate, negative, single and double roots, extremes
        send_item(0, 32'sh0001_0000, 32'sh0001_0000);
        send_item(0, 0, 0);
        send_item(32'sh0001_0000, 0, 32'sh0001_0000);
        send_item(32'sh0001_0000, 32'shFFFE_0000, 32'sh0001_0000);
        send_item(32'sh0001_0000, 0, 32'shFFFF_0000);
        send_item(32'sh0000_0001, 32'sh7FFF_FFFF, 0);
        send_item(32'sh0000_0001, 32'sh8000_0000, 0);
        send_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
        send_item(32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF);
        send_item(32'sh0000_0001, 32'sh0001_0000, 0);
        send_item(32'sh0000_0001, 0, 0);
        send_item(32'sh0000_0001, 32'sh0000_0002, 32'sh0000_0001);
        send_item(32'shFFFF_0000, 32'sh0003_0000, 32'sh0004_0000);
        // quotient of exactly -2^31 is not saturated: b = 2^15, a = 1
        send_item(32'sh0000_0001, 32'sh0000_8000, 0);
        send_item(32'sh0000_0002, 32'sh7FFF_FFFF, 32'sh8000_0000);

        // random, in idling phases
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct_send = (phase == 1 || phase == 3) ? ((phase == 3) ? 27 : 53) : 0;
            idle_pct_recv = (phase == 2 || phase == 3) ? ((phase == 3) ? 27 : 53) : 0;
            for (int n = 0; n < 280; n++)
            begin
                if ($urandom_range(99) < 60)
                    send_real_roots();
                else
                    send_item(pick_coef(), pick_coef(), pick_coef());
            end
            if (phase == 0)
            begin
                // sender pauses until every result is back
                wait_drained();
            end
        end

        // long receiver hold-off while the sender keeps offering items
        idle_pct_send = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int n = 0; n < 150; n++)
                    send_item(pick_coef(), pick_coef(), pick_coef());
            end
        join

        wait_drained();
        $display("sent %0d coefficient items, checked %0d root items", items_sent,
                 results_seen);
        $display("covered degenerate, complex, single, double and saturated roots");
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/qrrs_pkg.sv
rtl/core/qrrs_sqrt_cell.sv
rtl/core/qrrs_div_cell.sv
rtl/core/quadratic_real_root_solver.sv
rtl/core/qrrs_checker.sv
tb/sv/qrrs_checker.sv
tb/sv/tb_quadratic_real_root_solver.sv
